// ===== rtl/core/wheel_velocity_pid_mixer_assert.svh =====
// ----------------------------------------------------------------------------
// wheel velocity pid mixer assertion macros
// concurrent checks on i_clk, disabled while i_rst_n is low
// ----------------------------------------------------------------------------
`ifndef WHEEL_VELOCITY_PID_MIXER_ASSERT_SVH
`define WHEEL_VELOCITY_PID_MIXER_ASSERT_SVH
`ifndef SYNTHESIS
// antecedent implies consequent in the same cycle
`define WVPM_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> cons) \
        else $error("wvpm check failed");
// antecedent implies consequent in the next cycle
`define WVPM_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> cons) \
        else $error("wvpm check failed");
`else
`define WVPM_ASSERT_IMP(lbl, ante, cons)
`define WVPM_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ===== rtl/core/wvpm_pkg.sv =====
// ----------------------------------------------------------------------------
// wvpm_pkg
// shared types, widths and constants of the wheel velocity pid mixer
// ----------------------------------------------------------------------------
package wvpm_pkg;

    localparam int WHEEL_COUNT  = 4;
    localparam int WHEEL_IDX_W  = $clog2(WHEEL_COUNT);

    // fixed thresholds of the mixer
    localparam int FORCE_THRESHOLD = 200;
    localparam int DIST_THRESHOLD  = 25;
    localparam int LATERAL_CENTER  = 2050;

    // shared multiplier and accumulator widths
    localparam int MAC_A_W  = 33;
    localparam int MAC_B_W  = 17;
    localparam int PROD_W   = MAC_A_W + MAC_B_W;
    localparam int ACC_W    = PROD_W + 1;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PROP_GAIN    = 3'd0,
        CFG_INTEG_GAIN   = 3'd1,
        CFG_DERIV_GAIN   = 3'd2,
        CFG_MAX_CURRENT  = 3'd3,
        CFG_MAX_INTEGRAL = 3'd4,
        CFG_DRIVE_SCALE  = 3'd5,
        CFG_STRAFE_SCALE = 3'd6,
        CFG_SPEED_SCALE  = 3'd7
    } t_cfg_idx;

    localparam logic [15:0] RST_PROP_GAIN    = 16'd30000;
    localparam logic [15:0] RST_INTEG_GAIN   = 16'd1000;
    localparam logic [15:0] RST_DERIV_GAIN   = 16'd0;
    localparam logic [14:0] RST_MAX_CURRENT  = 15'd10000;
    localparam logic [23:0] RST_MAX_INTEGRAL = 24'd100000;
    localparam logic [15:0] RST_DRIVE_SCALE  = 16'd256;
    localparam logic [15:0] RST_STRAFE_SCALE = 16'd256;
    localparam logic [15:0] RST_SPEED_SCALE  = 16'd256;

    typedef struct packed {
        logic signed [15:0] force_reading;
        logic        [11:0] lateral_reading;
        logic        [15:0] obstacle_distance;
        logic               move_enable;
        logic signed [15:0] speed_front_right;
        logic signed [15:0] speed_back_right;
        logic signed [15:0] speed_front_left;
        logic signed [15:0] speed_back_left;
    } t_in_item;

    typedef struct packed {
        logic signed [15:0] current_front_right;
        logic signed [15:0] current_back_right;
        logic signed [15:0] current_front_left;
        logic signed [15:0] current_back_left;
    } t_out_item;

    // one multiply request to the shared unit
    typedef struct packed {
        logic valid;
        logic clr;
    } t_mac_ctl;

endpackage

// ===== rtl/core/wvpm_mac.sv =====
// ----------------------------------------------------------------------------
// wvpm_mac
// shared signed multiplier with registered product and accumulator
// ----------------------------------------------------------------------------
module wvpm_mac (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  wvpm_pkg::t_mac_ctl                   i_ctl,
    input  logic signed [wvpm_pkg::MAC_A_W-1:0]  i_a,
    input  logic signed [wvpm_pkg::MAC_B_W-1:0]  i_b,
    output logic signed [wvpm_pkg::ACC_W-1:0]    o_acc
);

    logic signed [wvpm_pkg::PROD_W-1:0] w_prod;
    logic signed [wvpm_pkg::PROD_W-1:0] r_prod;
    wvpm_pkg::t_mac_ctl                 r_ctl_d;
    logic signed [wvpm_pkg::ACC_W-1:0]  r_acc;
    logic signed [wvpm_pkg::ACC_W-1:0]  n_acc;

    assign w_prod = i_a * i_b;

    // product stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl_d <= '0;
        end else begin
            r_ctl_d <= i_ctl;
        end
        if (i_ctl.valid) begin
            r_prod <= w_prod;
        end
    end

    // accumulate stage
    always_comb begin
        n_acc = r_acc;
        if (r_ctl_d.valid) begin
            n_acc = (r_ctl_d.clr ? '0 : r_acc)
                  + wvpm_pkg::ACC_W'(r_prod);
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
    end

    assign o_acc = r_acc;

endmodule

// ===== rtl/core/wheel_velocity_pid_mixer.sv =====
// ----------------------------------------------------------------------------
// wheel_velocity_pid_mixer
// four wheel velocity mixer with per-wheel pid and anti-windup
// ----------------------------------------------------------------------------
// each input transaction carries a handle force, a lateral stick sample, an
// obstacle distance, a move flag and four raw wheel speeds; the block mixes
// them into four wheel targets (right wheels -(strafe+drive), left wheels
// drive-strafe, all zero without move), runs a pid per wheel against the
// scaled speeds and returns one transaction of four clamped currents. all
// products go through one shared 33x17 multiplier with a registered product
// and accumulator; every product passes an issue, a wait and a take state, and
// 18 products are needed (drive, strafe, then speed, p, d, i per wheel). an
// input transaction is taken only while the sequencer is idle, so a new one
// waits until the last is through. the drive and strafe products are followed
// by a target state, each wheel's products by an update state and the last
// update by an output state; with a free output the result turns valid in the
// same cycle as the sequencer returns to idle.
// the finished result sits in an output register, so a stalled output does
// not hold the next input off until a second result is ready.
// configuration is written through a plain write port (index, data) and is
// expected only while no transaction is in flight.
// ----------------------------------------------------------------------------
`include "wheel_velocity_pid_mixer_assert.svh"

module wheel_velocity_pid_mixer (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    // input channel
    input  logic                                    i_in_valid,
    output logic                                    o_in_stall,
    input  wvpm_pkg::t_in_item                      i_in_data,
    // output channel
    output logic                                    o_out_valid,
    input  logic                                    i_out_stall,
    output wvpm_pkg::t_out_item                     o_out_data,
    // configuration write port
    input  logic                                    i_cfg_we,
    input  logic [wvpm_pkg::CFG_IDX_W-1:0]          i_cfg_idx,
    input  logic [wvpm_pkg::CFG_DATA_W-1:0]         i_cfg_data
);

    localparam int TGT_W  = 33;   // target, drive, strafe, scaled speed
    localparam int ERR_W  = 32;   // saturated error
    localparam int DIFF_W = 33;   // error minus last error
    localparam int INT_W  = 25;   // integral, bounded by a 24-bit clamp
    localparam int CUR_W  = wvpm_pkg::ACC_W - 8;

    // sequencer states
    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_ISSUE  = 7'b0000010,
        ST_WAIT   = 7'b0000100,
        ST_TAKE   = 7'b0001000,
        ST_TARGET = 7'b0010000,
        ST_UPDATE = 7'b0100000,
        ST_OUT    = 7'b1000000
    } t_state;

    // which product the shared unit works on
    typedef enum logic [2:0] {
        OP_DRIVE  = 3'd0,
        OP_STRAFE = 3'd1,
        OP_SPEED  = 3'd2,
        OP_PROP   = 3'd3,
        OP_DERIV  = 3'd4,
        OP_INTEG  = 3'd5
    } t_op;

    // configuration registers
    logic [15:0] r_prop_gain;
    logic [15:0] r_integ_gain;
    logic [15:0] r_deriv_gain;
    logic [14:0] r_max_current;
    logic [23:0] r_max_integral;
    logic [15:0] r_drive_scale;
    logic [15:0] r_strafe_scale;
    logic [15:0] r_speed_scale;

    // sequencer
    t_state                          r_state, n_state;
    t_op                             r_op, n_op;
    logic [wvpm_pkg::WHEEL_IDX_W-1:0] r_wheel, n_wheel;

    // working registers
    wvpm_pkg::t_in_item              r_in;
    logic signed [TGT_W-1:0]         r_drive;
    logic signed [TGT_W-1:0]         r_strafe;
    logic signed [TGT_W-1:0]         r_tgt_right;
    logic signed [TGT_W-1:0]         r_tgt_left;
    logic signed [ERR_W-1:0]         r_err;
    logic signed [DIFF_W-1:0]        r_diff;
    logic                            r_hit;
    logic signed [15:0]              r_cur   [wvpm_pkg::WHEEL_COUNT];
    logic signed [INT_W-1:0]         r_integ [wvpm_pkg::WHEEL_COUNT];
    logic signed [ERR_W-1:0]         r_last  [wvpm_pkg::WHEEL_COUNT];

    // output register
    logic                            r_out_valid;
    wvpm_pkg::t_out_item             r_out;

    // shared unit
    wvpm_pkg::t_mac_ctl                      w_ctl;
    logic signed [wvpm_pkg::MAC_A_W-1:0]     w_a;
    logic signed [wvpm_pkg::MAC_B_W-1:0]     w_b;
    logic signed [wvpm_pkg::ACC_W-1:0]       w_acc;

    // datapath helpers
    logic                            w_accept;
    logic                            w_out_free;
    logic                            w_last_wheel;
    logic                            w_drive_on;
    logic signed [13:0]              w_lat_c;
    logic signed [15:0]              w_speed [wvpm_pkg::WHEEL_COUNT];
    logic signed [TGT_W-1:0]         w_tgt;
    logic signed [TGT_W:0]           w_err_raw;
    logic signed [ERR_W-1:0]         w_err_sat;
    logic signed [TGT_W-1:0]         w_sd_sum;
    logic signed [CUR_W-1:0]         w_cur_full;
    logic signed [CUR_W-1:0]         w_cur_lim;
    logic signed [15:0]              w_cur;
    logic                            w_cur_hit;
    logic signed [ERR_W:0]           w_isum;
    logic signed [ERR_W:0]           w_ilim;
    logic signed [ERR_W:0]           w_inew;
    logic signed [INT_W-1:0]         w_iclamp;
    logic signed [16:0]              w_olim;
    logic                            w_out_in_range;

    // ------------------------------------------------------------------
    // configuration writes, bits above a register's width are dropped
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prop_gain    <= wvpm_pkg::RST_PROP_GAIN;
            r_integ_gain   <= wvpm_pkg::RST_INTEG_GAIN;
            r_deriv_gain   <= wvpm_pkg::RST_DERIV_GAIN;
            r_max_current  <= wvpm_pkg::RST_MAX_CURRENT;
            r_max_integral <= wvpm_pkg::RST_MAX_INTEGRAL;
            r_drive_scale  <= wvpm_pkg::RST_DRIVE_SCALE;
            r_strafe_scale <= wvpm_pkg::RST_STRAFE_SCALE;
            r_speed_scale  <= wvpm_pkg::RST_SPEED_SCALE;
        end else if (i_cfg_we) begin
            case (wvpm_pkg::t_cfg_idx'(i_cfg_idx))
                wvpm_pkg::CFG_PROP_GAIN:    r_prop_gain    <= i_cfg_data[15:0];
                wvpm_pkg::CFG_INTEG_GAIN:   r_integ_gain   <= i_cfg_data[15:0];
                wvpm_pkg::CFG_DERIV_GAIN:   r_deriv_gain   <= i_cfg_data[15:0];
                wvpm_pkg::CFG_MAX_CURRENT:  r_max_current  <= i_cfg_data[14:0];
                wvpm_pkg::CFG_MAX_INTEGRAL: r_max_integral <= i_cfg_data[23:0];
                wvpm_pkg::CFG_DRIVE_SCALE:  r_drive_scale  <= i_cfg_data[15:0];
                wvpm_pkg::CFG_STRAFE_SCALE: r_strafe_scale <= i_cfg_data[15:0];
                wvpm_pkg::CFG_SPEED_SCALE:  r_speed_scale  <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // handshakes
    // ------------------------------------------------------------------
    assign o_in_stall   = (r_state != ST_IDLE);
    assign w_accept     = i_in_valid && !o_in_stall;
    assign w_out_free   = !r_out_valid || !i_out_stall;
    assign w_last_wheel = (r_wheel == wvpm_pkg::WHEEL_IDX_W'(wvpm_pkg::WHEEL_COUNT - 1));
    assign o_out_valid  = r_out_valid;
    assign o_out_data   = r_out;

    // wheel order: front right, back right, front left, back left
    assign w_speed[0] = r_in.speed_front_right;
    assign w_speed[1] = r_in.speed_back_right;
    assign w_speed[2] = r_in.speed_front_left;
    assign w_speed[3] = r_in.speed_back_left;

    // centered stick sample, -2050 .. 2045
    assign w_lat_c = $signed({2'b00, r_in.lateral_reading}) - 14'(wvpm_pkg::LATERAL_CENTER);

    // drive only with enough push and room ahead
    assign w_drive_on = (r_in.force_reading > 16'(wvpm_pkg::FORCE_THRESHOLD))
                     && (r_in.obstacle_distance > 16'(wvpm_pkg::DIST_THRESHOLD));

    // ------------------------------------------------------------------
    // operand select for the shared multiplier
    // ------------------------------------------------------------------
    always_comb begin
        w_ctl.valid = (r_state == ST_ISSUE);
        w_ctl.clr   = (r_op != OP_DERIV) && (r_op != OP_INTEG);
        w_a         = '0;
        w_b         = '0;
        case (r_op)
            OP_DRIVE: begin
                w_a = wvpm_pkg::MAC_A_W'(r_in.force_reading);
                w_b = $signed({1'b0, r_drive_scale});
            end
            OP_STRAFE: begin
                w_a = wvpm_pkg::MAC_A_W'(w_lat_c);
                w_b = $signed({1'b0, r_strafe_scale});
            end
            OP_SPEED: begin
                w_a = wvpm_pkg::MAC_A_W'(w_speed[r_wheel]);
                w_b = $signed({1'b0, r_speed_scale});
            end
            OP_PROP: begin
                w_a = wvpm_pkg::MAC_A_W'(r_err);
                w_b = $signed({1'b0, r_prop_gain});
            end
            OP_DERIV: begin
                w_a = wvpm_pkg::MAC_A_W'(r_diff);
                w_b = $signed({1'b0, r_deriv_gain});
            end
            OP_INTEG: begin
                w_a = wvpm_pkg::MAC_A_W'(r_integ[r_wheel]);
                w_b = $signed({1'b0, r_integ_gain});
            end
            default: ;
        endcase
    end

    wvpm_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_a     (w_a),
        .i_b     (w_b),
        .o_acc   (w_acc)
    );

    // ------------------------------------------------------------------
    // per-wheel arithmetic around the shared unit
    // ------------------------------------------------------------------
    // right wheels are 0 and 1, left wheels 2 and 3
    assign w_tgt     = r_wheel[1] ? r_tgt_left : r_tgt_right;
    assign w_err_raw = (TGT_W + 1)'(w_tgt) - (TGT_W + 1)'($signed(w_acc[TGT_W-1:0]));

    // error saturates to the signed 32-bit range
    always_comb begin
        if (w_err_raw[TGT_W] != w_err_raw[ERR_W-1] || w_err_raw[TGT_W-1] != w_err_raw[ERR_W-1]) begin
            w_err_sat = w_err_raw[TGT_W] ? {1'b1, {(ERR_W-1){1'b0}}}
                                         : {1'b0, {(ERR_W-1){1'b1}}};
        end else begin
            w_err_sat = w_err_raw[ERR_W-1:0];
        end
    end

    assign w_sd_sum = r_strafe + r_drive;

    // floor shift by 8 is a plain drop of the fraction bits
    assign w_cur_full = w_acc[wvpm_pkg::ACC_W-1:8];
    assign w_cur_lim  = $signed(CUR_W'(r_max_current));

    always_comb begin
        if (w_cur_full > w_cur_lim) begin
            w_cur     = 16'(w_cur_lim);
            w_cur_hit = 1'b1;
        end else if (w_cur_full < -w_cur_lim) begin
            w_cur     = 16'(-w_cur_lim);
            w_cur_hit = 1'b1;
        end else begin
            w_cur     = w_cur_full[15:0];
            w_cur_hit = 1'b0;
        end
    end

    // anti-windup: saturated output clears the integral
    assign w_isum = (ERR_W + 1)'(r_err) + (ERR_W + 1)'(r_integ[r_wheel]);
    assign w_ilim = $signed((ERR_W + 1)'(r_max_integral));
    assign w_inew = r_hit ? '0 : w_isum;

    always_comb begin
        if (w_inew > w_ilim) begin
            w_iclamp = INT_W'(w_ilim);
        end else if (w_inew < -w_ilim) begin
            w_iclamp = INT_W'(-w_ilim);
        end else begin
            w_iclamp = w_inew[INT_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        n_op    = r_op;
        n_wheel = r_wheel;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = ST_ISSUE;
                    n_op    = OP_DRIVE;
                    n_wheel = '0;
                end
            end
            ST_ISSUE: n_state = ST_WAIT;
            ST_WAIT:  n_state = ST_TAKE;
            ST_TAKE: begin
                case (r_op)
                    OP_DRIVE: begin
                        n_op    = OP_STRAFE;
                        n_state = ST_ISSUE;
                    end
                    OP_STRAFE: n_state = ST_TARGET;
                    OP_SPEED: begin
                        n_op    = OP_PROP;
                        n_state = ST_ISSUE;
                    end
                    OP_PROP: begin
                        n_op    = OP_DERIV;
                        n_state = ST_ISSUE;
                    end
                    OP_DERIV: begin
                        n_op    = OP_INTEG;
                        n_state = ST_ISSUE;
                    end
                    OP_INTEG: n_state = ST_UPDATE;
                    default:  n_state = ST_IDLE;
                endcase
            end
            ST_TARGET: begin
                n_op    = OP_SPEED;
                n_state = ST_ISSUE;
            end
            ST_UPDATE: begin
                if (w_last_wheel) begin
                    n_state = ST_OUT;
                end else begin
                    n_wheel = r_wheel + 1'b1;
                    n_op    = OP_SPEED;
                    n_state = ST_ISSUE;
                end
            end
            ST_OUT: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_op    <= OP_DRIVE;
            r_wheel <= '0;
        end else begin
            r_state <= n_state;
            r_op    <= n_op;
            r_wheel <= n_wheel;
        end
    end

    // ------------------------------------------------------------------
    // working registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in <= i_in_data;
        end
        if (r_state == ST_TAKE) begin
            case (r_op)
                OP_DRIVE:  r_drive  <= w_drive_on ? $signed(w_acc[TGT_W-1:0]) : '0;
                OP_STRAFE: r_strafe <= $signed(w_acc[TGT_W-1:0]);
                OP_SPEED:  r_err    <= w_err_sat;
                OP_PROP:   r_diff   <= DIFF_W'(r_err) - DIFF_W'(r_last[r_wheel]);
                OP_INTEG: begin
                    r_cur[r_wheel] <= w_cur;
                    r_hit          <= w_cur_hit;
                end
                default: ;
            endcase
        end
        if (r_state == ST_TARGET) begin
            r_tgt_right <= r_in.move_enable ? -w_sd_sum : '0;
            r_tgt_left  <= r_in.move_enable ? (r_drive - r_strafe) : '0;
        end
    end

    // wheel state, cleared by reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < wvpm_pkg::WHEEL_COUNT; i++) begin
                r_integ[i] <= '0;
                r_last[i]  <= '0;
            end
        end else if (r_state == ST_UPDATE) begin
            r_integ[r_wheel] <= w_iclamp;
            r_last[r_wheel]  <= r_err;
        end
    end

    // ------------------------------------------------------------------
    // output register
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == ST_OUT && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
        if (r_state == ST_OUT && w_out_free) begin
            r_out.current_front_right <= r_cur[0];
            r_out.current_back_right  <= r_cur[1];
            r_out.current_front_left  <= r_cur[2];
            r_out.current_back_left   <= r_cur[3];
        end
    end

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------
    assign w_olim = $signed(17'(r_max_current));
    assign w_out_in_range =
        (17'(r_out.current_front_right) <= w_olim) && (17'(r_out.current_front_right) >= -w_olim)
     && (17'(r_out.current_back_right)  <= w_olim) && (17'(r_out.current_back_right)  >= -w_olim)
     && (17'(r_out.current_front_left)  <= w_olim) && (17'(r_out.current_front_left)  >= -w_olim)
     && (17'(r_out.current_back_left)   <= w_olim) && (17'(r_out.current_back_left)   >= -w_olim);

    `WVPM_ASSERT_NXT(a_accept_starts_mix, w_accept, (r_state == ST_ISSUE && r_op == OP_DRIVE))
    `WVPM_ASSERT_IMP(a_issue_to_take, r_state == ST_ISSUE, ##2 (r_state == ST_TAKE))
    `WVPM_ASSERT_IMP(a_out_clamped, r_out_valid, w_out_in_range)
    `WVPM_ASSERT_NXT(a_out_loaded, (r_state == ST_OUT && w_out_free), r_out_valid)

endmodule

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the wheel velocity pid mixer
// ----------------------------------------------------------------------------
// every accepted tick is run through a cycle-free model of the mixer and the
// four wheel pid loops; the predicted currents wait in a queue and each
// returned transaction is compared field by field with the oldest one. a
// short table of directed ticks and register writes comes first (thresholds,
// clamp edges, saturated errors, masked register data), then phases of random
// ticks under reset, extreme and random settings, with bursty input traffic
// and a receiver that stalls on its own pattern
// ----------------------------------------------------------------------------
module tb;

    // block timing: the result delay of the block, used to size the final drain wait
    localparam int     OUT_LATENCY   = 61;
    localparam int     SETTLE_CYCLES = 4;
    localparam int     LONG_HOLD     = 400;
    localparam int     CYCLE_LIMIT   = 1000000;
    localparam int     PHASE_COUNT   = 10;
    localparam int     PHASE_TICKS   = 90;
    localparam longint ERR_MAX       = 64'sh0000_0000_7fff_ffff;
    localparam longint ERR_MIN       = -ERR_MAX - 1;

    // register settings used by the random phases
    typedef enum {SET_RESET, SET_MAX, SET_ZERO, SET_RANDOM} t_setting;

    // receiver behavior inside one window
    typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} t_stall_mode;

    // one row of the directed table: a register write or a tick
    typedef enum bit {ROW_WRITE, ROW_TICK} t_row_kind;
    typedef struct {
        t_row_kind           kind;
        wvpm_pkg::t_cfg_idx  reg_idx;
        logic [23:0]         reg_value;
        wvpm_pkg::t_in_item  tick;
        bit                  typed;
        wvpm_pkg::t_out_item want;
    } t_dir_row;

    // clock, reset and every block input start at a known value
    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    wvpm_pkg::t_in_item    in_data   = '0;
    logic                  out_stall = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [wvpm_pkg::CFG_IDX_W-1:0]  cfg_idx  = '0;
    logic [wvpm_pkg::CFG_DATA_W-1:0] cfg_data = '0;
    logic                  in_stall;
    logic                  out_valid;
    wvpm_pkg::t_out_item   out_data;

    // model state: register copy, wheel integrals, previous errors
    bit [23:0]   cfg_shadow [8];
    longint      wheel_integ    [wvpm_pkg::WHEEL_COUNT];
    longint      wheel_prev_err [wvpm_pkg::WHEEL_COUNT];

    wvpm_pkg::t_out_item pending_currents [$];
    t_dir_row    directed_rows [$];
    int          mismatch_cnt = 0;
    int          cycle_cnt    = 0;
    bit          hold_off_req = 1'b0;

    string       wheel_name [wvpm_pkg::WHEEL_COUNT] = '{"front_right", "back_right",
                                                       "front_left", "back_left"};

    t_setting    phase_plan [PHASE_COUNT] = '{SET_RESET, SET_MAX, SET_RANDOM, SET_ZERO,
                                             SET_RANDOM, SET_RANDOM, SET_RANDOM,
                                             SET_MAX, SET_RANDOM, SET_RANDOM};

    wheel_velocity_pid_mixer dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    // 12 unit period
    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // model of the block
    // ------------------------------------------------------------------------

    function automatic logic [23:0] reset_value(input wvpm_pkg::t_cfg_idx idx);
        case (idx)
            wvpm_pkg::CFG_PROP_GAIN:    return 24'(wvpm_pkg::RST_PROP_GAIN);
            wvpm_pkg::CFG_INTEG_GAIN:   return 24'(wvpm_pkg::RST_INTEG_GAIN);
            wvpm_pkg::CFG_DERIV_GAIN:   return 24'(wvpm_pkg::RST_DERIV_GAIN);
            wvpm_pkg::CFG_MAX_CURRENT:  return 24'(wvpm_pkg::RST_MAX_CURRENT);
            wvpm_pkg::CFG_MAX_INTEGRAL: return 24'(wvpm_pkg::RST_MAX_INTEGRAL);
            wvpm_pkg::CFG_DRIVE_SCALE:  return 24'(wvpm_pkg::RST_DRIVE_SCALE);
            wvpm_pkg::CFG_STRAFE_SCALE: return 24'(wvpm_pkg::RST_STRAFE_SCALE);
            default:                    return 24'(wvpm_pkg::RST_SPEED_SCALE);
        endcase
    endfunction

    function automatic void reset_model();
        for (int r = 0; r < 8; r++)
            cfg_shadow[r] = reset_value(wvpm_pkg::t_cfg_idx'(r));
        for (int w = 0; w < wvpm_pkg::WHEEL_COUNT; w++) begin
            wheel_integ[w]    = 0;
            wheel_prev_err[w] = 0;
        end
    endfunction

    // mix the tick into four targets, run each wheel pid, update the state
    function automatic wvpm_pkg::t_out_item predict_currents(input wvpm_pkg::t_in_item tick);
        longint      drive, strafe, err, sum, cur, acc, cur_lim, integ_lim, force_val;
        longint      target [wvpm_pkg::WHEEL_COUNT];
        longint      speed  [wvpm_pkg::WHEEL_COUNT];
        logic [15:0] amps   [wvpm_pkg::WHEEL_COUNT];
        bit          bite;
        wvpm_pkg::t_out_item res;
        drive     = 0;
        strafe    = 0;
        force_val = longint'($signed(tick.force_reading));
        speed[0]  = longint'($signed(tick.speed_front_right));
        speed[1]  = longint'($signed(tick.speed_back_right));
        speed[2]  = longint'($signed(tick.speed_front_left));
        speed[3]  = longint'($signed(tick.speed_back_left));
        if (tick.move_enable) begin
            // drive only above both thresholds, strictly
            if (force_val > wvpm_pkg::FORCE_THRESHOLD
                && longint'(tick.obstacle_distance) > wvpm_pkg::DIST_THRESHOLD)
                drive = force_val * longint'(cfg_shadow[wvpm_pkg::CFG_DRIVE_SCALE]);
            strafe = (longint'(tick.lateral_reading) - wvpm_pkg::LATERAL_CENTER)
                   * longint'(cfg_shadow[wvpm_pkg::CFG_STRAFE_SCALE]);
            target[0] = -(strafe + drive);
            target[1] = -(strafe + drive);
            target[2] = drive - strafe;
            target[3] = drive - strafe;
        end else begin
            for (int w = 0; w < wvpm_pkg::WHEEL_COUNT; w++)
                target[w] = 0;
        end
        cur_lim   = longint'(cfg_shadow[wvpm_pkg::CFG_MAX_CURRENT]);
        integ_lim = longint'(cfg_shadow[wvpm_pkg::CFG_MAX_INTEGRAL]);
        for (int w = 0; w < wvpm_pkg::WHEEL_COUNT; w++) begin
            err = target[w] - speed[w] * longint'(cfg_shadow[wvpm_pkg::CFG_SPEED_SCALE]);
            // wide error saturates to 32 bits before use and storage
            if (err > ERR_MAX)
                err = ERR_MAX;
            else if (err < ERR_MIN)
                err = ERR_MIN;
            sum = longint'(cfg_shadow[wvpm_pkg::CFG_PROP_GAIN]) * err
                + longint'(cfg_shadow[wvpm_pkg::CFG_DERIV_GAIN]) * (err - wheel_prev_err[w])
                + longint'(cfg_shadow[wvpm_pkg::CFG_INTEG_GAIN]) * wheel_integ[w];
            cur  = sum >>> 8;
            bite = 1'b0;
            if (cur > cur_lim) begin
                cur  = cur_lim;
                bite = 1'b1;
            end else if (cur < -cur_lim) begin
                cur  = -cur_lim;
                bite = 1'b1;
            end
            // anti-windup: a saturated current clears the integral
            acc = bite ? 0 : err + wheel_integ[w];
            if (acc > integ_lim)
                acc = integ_lim;
            else if (acc < -integ_lim)
                acc = -integ_lim;
            wheel_integ[w]    = acc;
            wheel_prev_err[w] = err;
            amps[w]           = cur[15:0];
        end
        res = {amps[0], amps[1], amps[2], amps[3]};
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------------

    // register write; the copy keeps only the bits the register holds
    task automatic write_reg(input wvpm_pkg::t_cfg_idx idx, input logic [23:0] value);
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= value;
        @(posedge clk);
        case (idx)
            wvpm_pkg::CFG_MAX_CURRENT:  cfg_shadow[idx] = {9'd0, value[14:0]};
            wvpm_pkg::CFG_MAX_INTEGRAL: cfg_shadow[idx] = value;
            default:                    cfg_shadow[idx] = {8'd0, value[15:0]};
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // offer one tick and hold it until the block takes it; the prediction is
    // made at the accepting edge, a typed value replaces it where given
    task automatic offer_tick(input wvpm_pkg::t_in_item tick, input bit typed,
                              input wvpm_pkg::t_out_item want);
        wvpm_pkg::t_out_item model;
        @(negedge clk);
        in_valid <= 1'b1;
        in_data  <= tick;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        model = predict_currents(tick);
        pending_currents.push_back(typed ? want : model);
    endtask

    // stop sending and wait until every predicted transaction has come back
    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_currents.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // value kept to a random number of low bits, so small gains show up often
    function automatic logic [23:0] scaled_value(input int width);
        int          k;
        logic [23:0] v;
        k = $urandom_range(0, width);
        v = 24'($urandom);
        if (k < 24)
            v = v & ((24'd1 << k) - 24'd1);
        return v;
    endfunction

    // write all eight registers; junk above each register's width must be dropped
    task automatic load_settings(input t_setting setting);
        wvpm_pkg::t_cfg_idx idx;
        logic [23:0] v, junk, mask;
        int          width;
        for (int r = 0; r < 8; r++) begin
            idx   = wvpm_pkg::t_cfg_idx'(r);
            width = (idx == wvpm_pkg::CFG_MAX_CURRENT)  ? 15 :
                    (idx == wvpm_pkg::CFG_MAX_INTEGRAL) ? 24 : 16;
            mask  = (24'd1 << width) - 24'd1;
            case (setting)
                SET_RESET: v = reset_value(idx);
                SET_MAX:   v = mask;
                SET_ZERO:  v = '0;
                default:   v = scaled_value(width);
            endcase
            junk = 24'($urandom);
            write_reg(idx, v | (junk & ~mask));
        end
    endtask

    function automatic wvpm_pkg::t_in_item random_tick();
        wvpm_pkg::t_in_item t;
        logic [15:0] spd [wvpm_pkg::WHEEL_COUNT];
        t.move_enable = ($urandom_range(0, 99) < 85);
        case ($urandom_range(0, 3))
            0:       t.force_reading = 16'($urandom_range(185, 215));
            1:       t.force_reading = 16'($urandom_range(0, 2000) - 1000);
            default: t.force_reading = 16'($urandom);
        endcase
        if ($urandom_range(0, 3) == 0)
            t.obstacle_distance = 16'($urandom_range(20, 31));
        else
            t.obstacle_distance = 16'($urandom);
        if ($urandom_range(0, 3) == 0)
            t.lateral_reading = 12'($urandom_range(2040, 2060));
        else
            t.lateral_reading = 12'($urandom);
        for (int w = 0; w < wvpm_pkg::WHEEL_COUNT; w++) begin
            case ($urandom_range(0, 2))
                0:       spd[w] = 16'($urandom);
                1:       spd[w] = 16'($urandom_range(0, 128) - 64);
                default: spd[w] = 16'($urandom_range(0, 4000) - 2000);
            endcase
        end
        t.speed_front_right = spd[0];
        t.speed_back_right  = spd[1];
        t.speed_front_left  = spd[2];
        t.speed_back_left   = spd[3];
        return t;
    endfunction

    // ------------------------------------------------------------------------
    // directed table
    // ------------------------------------------------------------------------

    function automatic wvpm_pkg::t_in_item mk_tick(input int force_v, input int lat,
                                                   input int dist_v, input int mv,
                                                   input int fr, input int br,
                                                   input int fl, input int bl);
        wvpm_pkg::t_in_item t;
        t.force_reading     = 16'(force_v);
        t.lateral_reading   = 12'(lat);
        t.obstacle_distance = 16'(dist_v);
        t.move_enable       = 1'(mv);
        t.speed_front_right = 16'(fr);
        t.speed_back_right  = 16'(br);
        t.speed_front_left  = 16'(fl);
        t.speed_back_left   = 16'(bl);
        return t;
    endfunction

    function automatic wvpm_pkg::t_out_item mk_amps(input int fr, input int br,
                                                    input int fl, input int bl);
        wvpm_pkg::t_out_item a;
        a.current_front_right = 16'(fr);
        a.current_back_right  = 16'(br);
        a.current_front_left  = 16'(fl);
        a.current_back_left   = 16'(bl);
        return a;
    endfunction

    function automatic void add_write(input wvpm_pkg::t_cfg_idx idx, input logic [23:0] value);
        t_dir_row row;
        row.kind      = ROW_WRITE;
        row.reg_idx   = idx;
        row.reg_value = value;
        row.tick      = '0;
        row.typed     = 1'b0;
        row.want      = '0;
        directed_rows.push_back(row);
    endfunction

    function automatic void add_tick(input wvpm_pkg::t_in_item tick, input bit typed,
                                     input wvpm_pkg::t_out_item want);
        t_dir_row row;
        row.kind      = ROW_TICK;
        row.reg_idx   = wvpm_pkg::CFG_PROP_GAIN;
        row.reg_value = '0;
        row.tick      = tick;
        row.typed     = typed;
        row.want      = want;
        directed_rows.push_back(row);
    endfunction

    function automatic void build_directed();
        // reset settings; inputs at their extremes but move off: all targets zero
        add_tick(mk_tick(32767, 4095, 65535, 0, 0, 0, 0, 0), 1'b1, mk_amps(0, 0, 0, 0));
        // full speed either way saturates every wheel at the reset current limit
        add_tick(mk_tick(0, 0, 0, 0, 32767, 32767, 32767, 32767), 1'b1,
                 mk_amps(-10000, -10000, -10000, -10000));
        add_tick(mk_tick(-32768, 2050, 0, 0, -32768, -32768, -32768, -32768), 1'b1,
                 mk_amps(10000, 10000, 10000, 10000));
        // moving with extreme handle and stick readings
        add_tick(mk_tick(32767, 4095, 65535, 1, 0, 0, 0, 0), 1'b0, '0);
        add_tick(mk_tick(-32768, 0, 0, 1, 0, 0, 0, 0), 1'b0, '0);
        // force and distance thresholds are strict
        add_tick(mk_tick(200, 2050, 26, 1, 1, -1, 2, -2), 1'b0, '0);
        add_tick(mk_tick(201, 2050, 25, 1, 0, 0, 0, 0), 1'b0, '0);
        add_tick(mk_tick(201, 2051, 26, 1, 0, 0, 0, 0), 1'b0, '0);
        add_tick(mk_tick(0, 2050, 100, 1, 0, 0, 0, 0), 1'b0, '0);

        // unit gain: current equals the negated raw speed; limit 100 written with junk high bits
        add_write(wvpm_pkg::CFG_PROP_GAIN, 24'd1);
        add_write(wvpm_pkg::CFG_INTEG_GAIN, 24'd0);
        add_write(wvpm_pkg::CFG_DERIV_GAIN, 24'd0);
        add_write(wvpm_pkg::CFG_MAX_CURRENT, 24'hff8064);
        add_write(wvpm_pkg::CFG_SPEED_SCALE, 24'd256);
        // exactly at the limit passes, one beyond is clamped
        add_tick(mk_tick(0, 2050, 0, 0, -100, 100, -101, 101), 1'b1,
                 mk_amps(100, -100, 100, -100));

        // zero current limit forces every current to zero
        add_write(wvpm_pkg::CFG_MAX_CURRENT, 24'd0);
        add_tick(mk_tick(500, 3000, 100, 1, 5, -7, 0, 32767), 1'b1, mk_amps(0, 0, 0, 0));

        // everything at maximum: errors overflow 32 bits and saturate
        add_write(wvpm_pkg::CFG_PROP_GAIN, 24'hffffff);
        add_write(wvpm_pkg::CFG_INTEG_GAIN, 24'hffffff);
        add_write(wvpm_pkg::CFG_DERIV_GAIN, 24'hffffff);
        add_write(wvpm_pkg::CFG_MAX_CURRENT, 24'hffffff);
        add_write(wvpm_pkg::CFG_MAX_INTEGRAL, 24'hffffff);
        add_write(wvpm_pkg::CFG_DRIVE_SCALE, 24'hffffff);
        add_write(wvpm_pkg::CFG_STRAFE_SCALE, 24'hffffff);
        add_write(wvpm_pkg::CFG_SPEED_SCALE, 24'hffffff);
        add_tick(mk_tick(32767, 2050, 65535, 1, 32767, 32767, -32768, -32768), 1'b0, '0);
        add_tick(mk_tick(32767, 4095, 65535, 1, -32768, -32768, 32767, 32767), 1'b0, '0);
        add_tick(mk_tick(-32768, 0, 0, 0, 32767, -32768, 32767, -32768), 1'b0, '0);

        // low gains: currents stay inside the limit, the integral clamp bites
        add_write(wvpm_pkg::CFG_PROP_GAIN, 24'd16);
        add_write(wvpm_pkg::CFG_INTEG_GAIN, 24'd4);
        add_write(wvpm_pkg::CFG_DERIV_GAIN, 24'd32);
        add_write(wvpm_pkg::CFG_MAX_CURRENT, 24'd32767);
        add_write(wvpm_pkg::CFG_MAX_INTEGRAL, 24'd1000);
        add_write(wvpm_pkg::CFG_DRIVE_SCALE, 24'd1);
        add_write(wvpm_pkg::CFG_STRAFE_SCALE, 24'd1);
        add_write(wvpm_pkg::CFG_SPEED_SCALE, 24'd1);
        add_tick(mk_tick(300, 2100, 100, 1, 3, -2, 1, 0), 1'b0, '0);
        add_tick(mk_tick(300, 2100, 100, 1, 3, -2, 1, 0), 1'b0, '0);
        add_tick(mk_tick(300, 2100, 100, 1, -4, 6, 2, -1), 1'b0, '0);
        add_tick(mk_tick(300, 2000, 100, 1, 0, 0, 0, 0), 1'b0, '0);
        add_tick(mk_tick(0, 2050, 10, 0, 10, -10, 20, -20), 1'b0, '0);
        add_tick(mk_tick(250, 1900, 30, 1, 1, 1, 1, 1), 1'b0, '0);
    endfunction

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------

    initial begin : stimulus
        int gap;
        int burst_left;
        reset_model();
        build_directed();
        // synchronous reset held from time zero, released on a falling edge
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed table: writes only once the block has drained
        foreach (directed_rows[r]) begin
            if (directed_rows[r].kind == ROW_WRITE) begin
                wait_idle();
                write_reg(directed_rows[r].reg_idx, directed_rows[r].reg_value);
            end else begin
                offer_tick(directed_rows[r].tick, directed_rows[r].typed, directed_rows[r].want);
            end
        end

        // random phases, each under its own register setting
        for (int phase = 0; phase < PHASE_COUNT; phase++) begin
            wait_idle();
            load_settings(phase_plan[phase]);
            burst_left = 0;
            for (int n = 0; n < PHASE_TICKS; n++) begin
                // long receiver hold-off while ticks keep coming: the block fills
                if (phase == 4 && n == 30)
                    hold_off_req = 1'b1;
                // sender pause until every result is back
                if (phase == 6 && n == 50)
                    wait_idle();
                if (burst_left == 0) begin
                    gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 80)
                                                      : $urandom_range(0, 6);
                    repeat (gap) begin
                        @(negedge clk);
                        in_valid <= 1'b0;
                    end
                    burst_left = $urandom_range(1, 16);
                end
                offer_tick(random_tick(), 1'b0, '0);
                burst_left--;
            end
        end

        // drain, then give a late or extra transaction the chance to show up
        wait_idle();
        repeat (OUT_LATENCY + 20) @(posedge clk);
        if (mismatch_cnt == 0 && pending_currents.size() == 0)
            $display("** wheel_velocity_pid_mixer: PASSED **");
        else
            $display("** wheel_velocity_pid_mixer: FAILED **");
        $finish;
    end

    // ------------------------------------------------------------------------
    // receiver: stall windows of random mode and length, plus the long hold
    // ------------------------------------------------------------------------

    initial begin : receiver
        t_stall_mode mode;
        int          span;
        int          period;
        forever begin
            mode   = t_stall_mode'($urandom_range(0, 3));
            span   = $urandom_range(20, 200);
            period = $urandom_range(2, 9);
            for (int k = 0; k < span; k++) begin
                @(negedge clk);
                if (hold_off_req) begin
                    out_stall <= 1'b1;
                    repeat (LONG_HOLD) @(negedge clk);
                    hold_off_req = 1'b0;
                end
                case (mode)
                    STALL_NONE:  out_stall <= 1'b0;
                    STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
                    STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
                    default:     out_stall <= ((k % period) < (period / 2));
                endcase
            end
        end
    end

    // ------------------------------------------------------------------------
    // checking: each accepted transaction against the oldest prediction
    // ------------------------------------------------------------------------

    always @(posedge clk) begin : result_check
        wvpm_pkg::t_out_item want;
        int                  hi;
        if (rst_n && out_valid && !out_stall) begin
            if (pending_currents.size() == 0) begin
                mismatch_cnt++;
                $display("%0t: result with none expected, got %h", $time, out_data);
            end else begin
                want = pending_currents.pop_front();
                for (int w = 0; w < wvpm_pkg::WHEEL_COUNT; w++) begin
                    hi = 16 * wvpm_pkg::WHEEL_COUNT - 1 - 16 * w;
                    if (want[hi -: 16] !== out_data[hi -: 16]) begin
                        mismatch_cnt++;
                        $display("%0t: current_%s expected %0d, got %0d", $time, wheel_name[w],
                                 $signed(want[hi -: 16]), $signed(out_data[hi -: 16]));
                    end
                end
            end
        end
    end

    // watchdog
    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("** wheel_velocity_pid_mixer: FAILED **");
            $finish;
        end
    end

endmodule
